FILE: design/bphc_pkg.sv
// Shared types, constants and helpers of the button press and hold classifier.
package bphc_pkg;

   // Fixed field widths.
   localparam int BUTTON_W    = 3;
   localparam int KIND_W      = 3;
   localparam int VALUE_W     = 16;
   localparam int CFG_W       = 16;
   localparam int RUN_W       = 8;
   localparam int CSR_INDEX_W = 3;

   // Events per item and the width of their count.
   localparam int MAX_EVENTS = 3;
   localparam int EVT_CNT_W  = 2;

   // Depth of the queue between the front and back parts.
   localparam int FIFO_DEPTH = 4;

   // Defaults of the top level parameters.
   localparam int DEF_NUM_BUTTONS = 8;
   localparam int DEF_TICK_BITS   = 16;

   localparam logic [RUN_W-1:0]   RUN_MAX   = 8'hFF;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 16'hFFFF;

   // Register reset values.
   localparam logic [CFG_W-1:0] RST_MODE_BITS        = 16'h807F;
   localparam logic [RUN_W-1:0] RST_DEBOUNCE_COUNT   = 8'd3;
   localparam logic [CFG_W-1:0] RST_CLICK_GAP_TICKS  = 16'd20;
   localparam logic [CFG_W-1:0] RST_HOLD_START_TICKS = 16'd50;
   localparam logic [CFG_W-1:0] RST_HOLD_MARK_ONE    = 16'd100;
   localparam logic [CFG_W-1:0] RST_HOLD_MARK_THREE  = 16'd300;
   localparam logic [CFG_W-1:0] RST_HOLD_MARK_FIVE   = 16'd500;
   localparam logic [CFG_W-1:0] RST_HOLD_MARK_TEN    = 16'd1000;

   typedef enum logic [KIND_W-1:0] {
      KIND_FALL     = 3'd0,
      KIND_RISE     = 3'd1,
      KIND_CLICKS   = 3'd2,
      KIND_RELEASE  = 3'd3,
      KIND_HOLD     = 3'd4,
      KIND_INDICATE = 3'd5
   } evt_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MODE_BITS        = 3'd0,
      REG_DEBOUNCE_COUNT   = 3'd1,
      REG_CLICK_GAP_TICKS  = 3'd2,
      REG_HOLD_START_TICKS = 3'd3,
      REG_HOLD_MARK_ONE    = 3'd4,
      REG_HOLD_MARK_THREE  = 3'd5,
      REG_HOLD_MARK_FIVE   = 3'd6,
      REG_HOLD_MARK_TEN    = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic [CFG_W-1:0] mode_bits;
      logic [RUN_W-1:0] debounce_count;
      logic [CFG_W-1:0] click_gap_ticks;
      logic [CFG_W-1:0] hold_start_ticks;
      logic [CFG_W-1:0] hold_mark_one;
      logic [CFG_W-1:0] hold_mark_three;
      logic [CFG_W-1:0] hold_mark_five;
      logic [CFG_W-1:0] hold_mark_ten;
   } cfg_type;

   typedef struct packed {
      evt_kind_type       kind;
      logic [VALUE_W-1:0] value;
   } evt_type;

   // All events caused by one item, packed from slot zero upward.
   typedef struct packed {
      logic [BUTTON_W-1:0]         button;
      logic [EVT_CNT_W-1:0]        num;
      evt_type [MAX_EVENTS-1:0]    evt;
   } bundle_type;

   // Run counter increment that stops at all ones.
   function automatic logic [RUN_W-1:0] sat_run_inc(input logic [RUN_W-1:0] v);
      return (v == RUN_MAX) ? v : v + RUN_W'(1);
   endfunction

endpackage

FILE: design/button_press_hold_classifier.sv
// Button press and hold classifier: top level with configuration registers.
//
// Usage: each req_ item is one scan sample of one button (req_button_id,
// req_pin_active). The block debounces each button and reports edges,
// click counts, releases, hold milestones and an indicate pulse on the
// rsp_ channel, one event per item on that channel; rsp_last_event marks
// the final event caused by one sample. A sample may cause zero to three
// events. Samples of buttons at or beyond NUM_BUTTONS are taken and dropped.
// Registers are written over the csr_ channel, which is always ready;
// write them only while the block is idle.
// Flow: the first event of a sample passes through the event queue and then
// the result register. A sample is taken every cycle while the four-entry
// event queue has room; the single result register drains one event per
// cycle while the receiver is ready, so samples raising more than one event
// fill the queue faster than it drains. If the receiver stalls, the result
// register holds, the queue fills and req_ready falls until room frees up.
// Reset clears all button state, the queue and the result register, and
// loads the register defaults.
module button_press_hold_classifier import bphc_pkg::*; #(
   parameter int NUM_BUTTONS = DEF_NUM_BUTTONS,
   parameter int TICK_BITS   = DEF_TICK_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [BUTTON_W-1:0]    req_button_id,
   input  logic                   req_pin_active,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BUTTON_W-1:0]    rsp_event_button,
   output logic [KIND_W-1:0]      rsp_event_kind,
   output logic [VALUE_W-1:0]     rsp_event_value,
   output logic                   rsp_last_event,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   cfg_type    cfg_ff;
   logic       csr_write;
   logic       push_valid;
   bundle_type push_bundle;
   logic       queue_full;
   bundle_type head_bundle;
   logic       queue_empty;
   logic       pop;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode_bits        <= RST_MODE_BITS;
         cfg_ff.debounce_count   <= RST_DEBOUNCE_COUNT;
         cfg_ff.click_gap_ticks  <= RST_CLICK_GAP_TICKS;
         cfg_ff.hold_start_ticks <= RST_HOLD_START_TICKS;
         cfg_ff.hold_mark_one    <= RST_HOLD_MARK_ONE;
         cfg_ff.hold_mark_three  <= RST_HOLD_MARK_THREE;
         cfg_ff.hold_mark_five   <= RST_HOLD_MARK_FIVE;
         cfg_ff.hold_mark_ten    <= RST_HOLD_MARK_TEN;
      end else if (csr_write) begin
         unique case (csr_reg_type'(csr_index))
            REG_MODE_BITS:        cfg_ff.mode_bits        <= csr_data;
            REG_DEBOUNCE_COUNT:   cfg_ff.debounce_count   <= csr_data[RUN_W-1:0];
            REG_CLICK_GAP_TICKS:  cfg_ff.click_gap_ticks  <= csr_data;
            REG_HOLD_START_TICKS: cfg_ff.hold_start_ticks <= csr_data;
            REG_HOLD_MARK_ONE:    cfg_ff.hold_mark_one    <= csr_data;
            REG_HOLD_MARK_THREE:  cfg_ff.hold_mark_three  <= csr_data;
            REG_HOLD_MARK_FIVE:   cfg_ff.hold_mark_five   <= csr_data;
            REG_HOLD_MARK_TEN:    cfg_ff.hold_mark_ten    <= csr_data;
         endcase
      end
   end

   bphc_front #(
      .NUM_BUTTONS (NUM_BUTTONS),
      .TICK_BITS   (TICK_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_button_id  (req_button_id),
      .req_pin_active (req_pin_active),
      .queue_full     (queue_full),
      .push_valid     (push_valid),
      .push_bundle    (push_bundle)
   );

   bphc_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_bundle (push_bundle),
      .full        (queue_full),
      .pop         (pop),
      .head_bundle (head_bundle),
      .empty       (queue_empty)
   );

   bphc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_bundle      (head_bundle),
      .empty            (queue_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_button (rsp_event_button),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_value  (rsp_event_value),
      .rsp_last_event   (rsp_last_event)
   );

endmodule

FILE: design/bphc_front.sv
// Front part: per-button debounce and phase state, classifies each item into events.
module bphc_front import bphc_pkg::*; #(
   parameter int NUM_BUTTONS = DEF_NUM_BUTTONS,
   parameter int TICK_BITS   = DEF_TICK_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BUTTON_W-1:0] req_button_id,
   input  logic                req_pin_active,
   input  logic                queue_full,
   output logic                push_valid,
   output bundle_type          push_bundle
);

   localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int CMP_W = (TICK_BITS > VALUE_W) ? TICK_BITS : VALUE_W;
   localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

   // Per-button state.
   logic [RUN_W-1:0]     active_run_ff   [NUM_BUTTONS];
   logic [RUN_W-1:0]     inactive_run_ff [NUM_BUTTONS];
   logic                 level_seen_ff   [NUM_BUTTONS];
   logic [TICK_BITS-1:0] phase_ticks_ff  [NUM_BUTTONS];
   logic [RUN_W-1:0]     click_count_ff  [NUM_BUTTONS];
   logic [TICK_BITS-1:0] hold_ticks_ff   [NUM_BUTTONS];

   logic [RUN_W-1:0]     active_run_in;
   logic [RUN_W-1:0]     inactive_run_in;
   logic                 level_seen_in;
   logic [TICK_BITS-1:0] phase_ticks_in;
   logic [RUN_W-1:0]     click_count_in;
   logic [TICK_BITS-1:0] hold_ticks_in;

   logic [IDX_W-1:0]     idx;
   logic                 in_range;
   logic                 accept;
   logic                 update;
   logic                 logic_en;
   logic                 edge_en;

   // Values between the release path and the press path.
   logic [RUN_W-1:0]     inactive_mid;
   logic                 level_mid;
   logic [TICK_BITS-1:0] phase_mid;
   logic [RUN_W-1:0]     click_mid;
   logic [TICK_BITS-1:0] hold_mid;
   logic                 rel_ok;
   logic                 prs_ok;
   logic                 tick_adv;
   logic                 mark_hit;
   logic [CMP_W-1:0]     phase_cmp;

   // Candidate events in their output order.
   logic                 a_valid;
   evt_kind_type         a_kind;
   logic [VALUE_W-1:0]   a_value;
   logic                 rise_valid;
   logic                 ind_valid;
   logic                 hold_valid;
   logic [VALUE_W-1:0]   hold_value;
   logic [EVT_CNT_W-1:0] num;

   // Clamp a tick count to the event value width.
   function automatic logic [VALUE_W-1:0] sat_value(input logic [TICK_BITS-1:0] t);
      logic [CMP_W-1:0] w;
      w = CMP_W'(t);
      if (w > CMP_W'(VALUE_MAX)) begin
         return VALUE_MAX;
      end
      return w[VALUE_W-1:0];
   endfunction

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign in_range  = ({1'b0, req_button_id} < (BUTTON_W + 1)'(NUM_BUTTONS));
   assign update    = accept && in_range;
   assign idx       = req_button_id[IDX_W-1:0];
   assign logic_en  = cfg.mode_bits[{1'b0, req_button_id}];
   assign edge_en   = cfg.mode_bits[{1'b1, req_button_id}];

   // Release path, then press path, on the selected button.
   always_comb begin
      active_run_in = req_pin_active ? sat_run_inc(active_run_ff[idx]) : '0;
      inactive_mid  = req_pin_active ? inactive_run_ff[idx]
                                     : sat_run_inc(inactive_run_ff[idx]);
      rel_ok = (inactive_mid >= cfg.debounce_count);
      prs_ok = (active_run_in >= cfg.debounce_count);

      level_mid = level_seen_ff[idx];
      phase_mid = phase_ticks_ff[idx];
      click_mid = click_count_ff[idx];
      hold_mid  = hold_ticks_ff[idx];
      a_valid   = 1'b0;
      a_kind    = KIND_FALL;
      a_value   = '0;

      if (rel_ok) begin
         if (level_seen_ff[idx]) begin
            level_mid = 1'b0;
            a_valid   = edge_en;
            phase_mid = TICK_BITS'(inactive_mid);
         end else begin
            if (phase_ticks_ff[idx] != TICK_MAX) begin
               phase_mid = phase_ticks_ff[idx] + TICK_BITS'(1);
            end
            if (CMP_W'(phase_mid) >= CMP_W'(cfg.click_gap_ticks)) begin
               if (hold_ticks_ff[idx] != '0) begin
                  a_valid = logic_en;
                  a_kind  = KIND_RELEASE;
                  a_value = sat_value(hold_ticks_ff[idx]);
               end else if (logic_en && click_count_ff[idx] != '0) begin
                  a_valid = 1'b1;
                  a_kind  = KIND_CLICKS;
                  a_value = VALUE_W'(click_count_ff[idx]);
               end
               hold_mid  = '0;
               click_mid = '0;
            end
         end
      end

      inactive_run_in = inactive_mid;
      level_seen_in   = level_mid;
      phase_ticks_in  = phase_mid;
      click_count_in  = click_mid;
      hold_ticks_in   = hold_mid;
      rise_valid      = 1'b0;
      ind_valid       = 1'b0;
      hold_valid      = 1'b0;
      hold_value      = '0;
      tick_adv        = 1'b0;
      mark_hit        = 1'b0;
      phase_cmp       = '0;

      if (prs_ok) begin
         inactive_run_in = '0;
         if (!level_mid) begin
            level_seen_in  = 1'b1;
            rise_valid     = edge_en;
            ind_valid      = 1'b1;
            phase_ticks_in = TICK_BITS'(active_run_in);
            click_count_in = sat_run_inc(click_mid);
         end else begin
            tick_adv = (phase_mid != TICK_MAX);
            if (tick_adv) begin
               phase_ticks_in = phase_mid + TICK_BITS'(1);
            end
            phase_cmp = CMP_W'(phase_ticks_in);
            mark_hit  = (phase_cmp == CMP_W'(cfg.hold_start_ticks)) ||
                        (phase_cmp == CMP_W'(cfg.hold_mark_one)) ||
                        (phase_cmp == CMP_W'(cfg.hold_mark_three)) ||
                        (phase_cmp == CMP_W'(cfg.hold_mark_five)) ||
                        (phase_cmp == CMP_W'(cfg.hold_mark_ten));
            if (phase_cmp >= CMP_W'(cfg.hold_start_ticks)) begin
               click_count_in = '0;
               hold_ticks_in  = phase_ticks_in;
               hold_valid     = tick_adv && logic_en && mark_hit;
               hold_value     = sat_value(phase_ticks_in);
            end
         end
      end
   end

   // Pack the events of this item from slot zero upward.
   always_comb begin
      push_bundle        = '0;
      push_bundle.button = req_button_id;
      num                = '0;
      if (a_valid) begin
         push_bundle.evt[num].kind  = a_kind;
         push_bundle.evt[num].value = a_value;
         num = num + EVT_CNT_W'(1);
      end
      if (rise_valid) begin
         push_bundle.evt[num].kind  = KIND_RISE;
         push_bundle.evt[num].value = '0;
         num = num + EVT_CNT_W'(1);
      end
      if (ind_valid) begin
         push_bundle.evt[num].kind  = KIND_INDICATE;
         push_bundle.evt[num].value = '0;
         num = num + EVT_CNT_W'(1);
      end
      if (hold_valid) begin
         push_bundle.evt[num].kind  = KIND_HOLD;
         push_bundle.evt[num].value = hold_value;
         num = num + EVT_CNT_W'(1);
      end
      push_bundle.num = num;
   end

   assign push_valid = update && (num != '0);

   // State write-back for the selected button.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            active_run_ff[i]   <= '0;
            inactive_run_ff[i] <= '0;
            level_seen_ff[i]   <= 1'b0;
            phase_ticks_ff[i]  <= '0;
            click_count_ff[i]  <= '0;
            hold_ticks_ff[i]   <= '0;
         end
      end else if (update) begin
         active_run_ff[idx]   <= active_run_in;
         inactive_run_ff[idx] <= inactive_run_in;
         level_seen_ff[idx]   <= level_seen_in;
         phase_ticks_ff[idx]  <= phase_ticks_in;
         click_count_ff[idx]  <= click_count_in;
         hold_ticks_ff[idx]   <= hold_ticks_in;
      end
   end

endmodule

FILE: design/bphc_fifo.sv
// Short queue of event bundles between the front and back parts.
module bphc_fifo import bphc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  bundle_type push_bundle,
   output logic       full,
   input  logic       pop,
   output bundle_type head_bundle,
   output logic       empty
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   bundle_type       mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full        = (count_ff == (PTR_W + 1)'(FIFO_DEPTH));
   assign empty       = (count_ff == '0);
   assign do_push     = push_valid && !full;
   assign do_pop      = pop && !empty;
   assign head_bundle = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

FILE: design/bphc_back.sv
// Back part: drains each bundle one event per cycle, while the receiver is ready, into the result register.
module bphc_back import bphc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  bundle_type          head_bundle,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BUTTON_W-1:0] rsp_event_button,
   output logic [KIND_W-1:0]   rsp_event_kind,
   output logic [VALUE_W-1:0]  rsp_event_value,
   output logic                rsp_last_event
);

   logic [EVT_CNT_W-1:0] ev_idx_ff, ev_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BUTTON_W-1:0]  rsp_button_ff;
   evt_kind_type         rsp_kind_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic                 rsp_last_ff;
   logic                 load;
   logic                 last;
   evt_type              cur;

   // Load the next event whenever the result register is free or being taken.
   assign load = !empty && (!rsp_valid_ff || rsp_ready);
   assign cur  = head_bundle.evt[ev_idx_ff];
   assign last = (ev_idx_ff == head_bundle.num - EVT_CNT_W'(1));
   assign pop  = load && last;

   always_comb begin
      ev_idx_in    = ev_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         ev_idx_in    = last ? '0 : ev_idx_ff + EVT_CNT_W'(1);
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ev_idx_ff    <= ev_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_button_ff <= head_bundle.button;
         rsp_kind_ff   <= cur.kind;
         rsp_value_ff  <= cur.value;
         rsp_last_ff   <= last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_button = rsp_button_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_event_value  = rsp_value_ff;
   assign rsp_last_event   = rsp_last_ff;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the button press and hold classifier, with its own event predictor.
module tb_top;
   import bphc_pkg::*;

   localparam int NBTN             = DEF_NUM_BUTTONS;
   localparam int TICK_W           = DEF_TICK_BITS;
   localparam int NUM_REGS         = 8;
   localparam int CLK_HALF_NS      = 4;
   localparam int RESET_CYCLES     = 11;
   localparam int MAX_IDLE         = 18;
   localparam int SETTLE_CYCLES    = 8;
   localparam int SHOWN_MISMATCHES = 10;
   localparam int PHASE_ITEMS      = 47;
   localparam int N_DIRECTED       = 22;
   localparam longint RUN_LIMIT_NS = 64'd10_000_000;

   // One event as it leaves the block.
   typedef struct {
      logic [BUTTON_W-1:0] button;
      evt_kind_type        kind;
      logic [VALUE_W-1:0]  value;
      logic                last;
   } evt_rec_type;

   // One row of the directed table; typed rows carry a hand-read event count.
   typedef struct {
      logic [BUTTON_W-1:0] button;
      logic                pin;
      bit                  typed;
      int                  typed_num;
      evt_kind_type        typed_kind;
   } sample_row_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic [BUTTON_W-1:0]    req_button_id  = '0;
   logic                   req_pin_active = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic [BUTTON_W-1:0]    rsp_event_button;
   logic [KIND_W-1:0]      rsp_event_kind;
   logic [VALUE_W-1:0]     rsp_event_value;
   logic                   rsp_last_event;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CFG_W-1:0]       csr_data       = '0;

   // Predicted register file and per-button debounce state.
   cfg_type             cfg_shadow;
   logic [RUN_W-1:0]    act_run  [NBTN];
   logic [RUN_W-1:0]    idle_run [NBTN];
   logic                pressed  [NBTN];
   logic [TICK_W-1:0]   ticks    [NBTN];
   logic [RUN_W-1:0]    clicks   [NBTN];
   logic [TICK_W-1:0]   held     [NBTN];

   evt_rec_type         fresh_events [MAX_EVENTS];
   int                  fresh_count;
   evt_rec_type         pending_events [$];
   logic [CFG_W-1:0]    next_regs [NUM_REGS];

   bit                  send_idle_on = 1'b0;
   bit                  rsp_idle_on  = 1'b0;
   int                  fail_count   = 0;
   int                  samples_sent = 0;
   int                  results_seen = 0;
   int                  config_loads = 0;

   // Directed samples under the reset settings: button 0 has logic events only,
   // button 7 has edge events only.
   sample_row_type directed_rows [N_DIRECTED] = '{
      '{3'd0, 1'b1, 1'b1, 0, KIND_FALL},
      '{3'd0, 1'b1, 1'b1, 0, KIND_FALL},
      '{3'd0, 1'b1, 1'b1, 1, KIND_INDICATE},
      '{3'd7, 1'b1, 1'b1, 0, KIND_FALL},
      '{3'd7, 1'b1, 1'b1, 0, KIND_FALL},
      '{3'd7, 1'b1, 1'b1, 2, KIND_RISE},
      '{3'd0, 1'b0, 1'b1, 0, KIND_FALL},
      '{3'd0, 1'b0, 1'b1, 0, KIND_FALL},
      '{3'd0, 1'b0, 1'b1, 0, KIND_FALL},
      '{3'd7, 1'b0, 1'b1, 0, KIND_FALL},
      '{3'd7, 1'b0, 1'b1, 0, KIND_FALL},
      '{3'd7, 1'b0, 1'b1, 1, KIND_FALL},
      '{3'd5, 1'b1, 1'b0, 0, KIND_FALL},
      '{3'd5, 1'b0, 1'b0, 0, KIND_FALL},
      '{3'd5, 1'b1, 1'b0, 0, KIND_FALL},
      '{3'd5, 1'b1, 1'b0, 0, KIND_FALL},
      '{3'd5, 1'b1, 1'b0, 0, KIND_FALL},
      '{3'd2, 1'b0, 1'b0, 0, KIND_FALL},
      '{3'd6, 1'b1, 1'b0, 0, KIND_FALL},
      '{3'd3, 1'b0, 1'b0, 0, KIND_FALL},
      '{3'd4, 1'b1, 1'b0, 0, KIND_FALL},
      '{3'd1, 1'b0, 1'b0, 0, KIND_FALL}
   };

   button_press_hold_classifier dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_button_id    (req_button_id),
      .req_pin_active   (req_pin_active),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_button (rsp_event_button),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_value  (rsp_event_value),
      .rsp_last_event   (rsp_last_event),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #(CLK_HALF_NS) clock = ~clock;

   // Reset values of the predicted registers and button state.
   function automatic void clear_shadow();
      cfg_shadow.mode_bits        = RST_MODE_BITS;
      cfg_shadow.debounce_count   = RST_DEBOUNCE_COUNT;
      cfg_shadow.click_gap_ticks  = RST_CLICK_GAP_TICKS;
      cfg_shadow.hold_start_ticks = RST_HOLD_START_TICKS;
      cfg_shadow.hold_mark_one    = RST_HOLD_MARK_ONE;
      cfg_shadow.hold_mark_three  = RST_HOLD_MARK_THREE;
      cfg_shadow.hold_mark_five   = RST_HOLD_MARK_FIVE;
      cfg_shadow.hold_mark_ten    = RST_HOLD_MARK_TEN;
      for (int i = 0; i < NBTN; i++) begin
         act_run[i]  = '0;
         idle_run[i] = '0;
         pressed[i]  = 1'b0;
         ticks[i]    = '0;
         clicks[i]   = '0;
         held[i]     = '0;
      end
   endfunction

   // A register write as the block sees it; the debounce count keeps its low byte.
   function automatic void apply_reg(input csr_reg_type reg_id, input logic [CFG_W-1:0] data);
      case (reg_id)
         REG_MODE_BITS:        cfg_shadow.mode_bits        = data;
         REG_DEBOUNCE_COUNT:   cfg_shadow.debounce_count   = data[RUN_W-1:0];
         REG_CLICK_GAP_TICKS:  cfg_shadow.click_gap_ticks  = data;
         REG_HOLD_START_TICKS: cfg_shadow.hold_start_ticks = data;
         REG_HOLD_MARK_ONE:    cfg_shadow.hold_mark_one    = data;
         REG_HOLD_MARK_THREE:  cfg_shadow.hold_mark_three  = data;
         REG_HOLD_MARK_FIVE:   cfg_shadow.hold_mark_five   = data;
         REG_HOLD_MARK_TEN:    cfg_shadow.hold_mark_ten    = data;
         default: ;
      endcase
   endfunction

   // Phase tick counter that sticks at all ones; tells whether it moved.
   function automatic logic bump_ticks(input logic [BUTTON_W-1:0] b);
      if (ticks[b] == '1) return 1'b0;
      ticks[b] = ticks[b] + 1'b1;
      return 1'b1;
   endfunction

   function automatic void add_event(inout int n, input logic [BUTTON_W-1:0] b,
                                     input evt_kind_type kind, input logic [VALUE_W-1:0] value);
      if (n >= MAX_EVENTS) return;
      fresh_events[n] = '{b, kind, value, 1'b0};
      n++;
   endfunction

   // Works out the events that one accepted sample raises and advances the button state.
   function automatic int classify_sample(input logic [BUTTON_W-1:0] b, input logic act);
      int                n;
      logic              logic_en;
      logic              edge_en;
      logic              adv;
      logic [TICK_W-1:0] t;
      n = 0;
      if (act) begin
         if (act_run[b] != RUN_MAX) act_run[b] = act_run[b] + 1'b1;
      end else begin
         if (idle_run[b] != RUN_MAX) idle_run[b] = idle_run[b] + 1'b1;
         act_run[b] = '0;
      end
      logic_en = cfg_shadow.mode_bits[b];
      edge_en  = cfg_shadow.mode_bits[8 + b];

      // Release side: falling edge, or clicks or a release once the gap has passed.
      if (idle_run[b] >= cfg_shadow.debounce_count) begin
         if (pressed[b]) begin
            pressed[b] = 1'b0;
            if (edge_en) add_event(n, b, KIND_FALL, '0);
            ticks[b] = TICK_W'(idle_run[b]);
         end else begin
            void'(bump_ticks(b));
            if (ticks[b] >= cfg_shadow.click_gap_ticks) begin
               if (held[b] != '0) begin
                  if (logic_en) add_event(n, b, KIND_RELEASE, held[b]);
               end else if (logic_en && clicks[b] != '0) begin
                  add_event(n, b, KIND_CLICKS, VALUE_W'(clicks[b]));
               end
               held[b]   = '0;
               clicks[b] = '0;
            end
         end
      end

      // Press side: rising edge and indicate, or hold milestones while pressed.
      if (act_run[b] >= cfg_shadow.debounce_count) begin
         idle_run[b] = '0;
         if (!pressed[b]) begin
            pressed[b] = 1'b1;
            if (edge_en) add_event(n, b, KIND_RISE, '0);
            add_event(n, b, KIND_INDICATE, '0);
            ticks[b] = TICK_W'(act_run[b]);
            if (clicks[b] != RUN_MAX) clicks[b] = clicks[b] + 1'b1;
         end else begin
            adv = bump_ticks(b);
            if (ticks[b] >= cfg_shadow.hold_start_ticks) begin
               t         = ticks[b];
               clicks[b] = '0;
               held[b]   = t;
               if (adv && logic_en &&
                   (t == cfg_shadow.hold_start_ticks || t == cfg_shadow.hold_mark_one ||
                    t == cfg_shadow.hold_mark_three || t == cfg_shadow.hold_mark_five ||
                    t == cfg_shadow.hold_mark_ten))
                  add_event(n, b, KIND_HOLD, t);
            end
         end
      end

      if (n > 0) fresh_events[n - 1].last = 1'b1;
      return n;
   endfunction

   // Offers one sample, waits for the handshake and queues its predicted events.
   task automatic send_sample(input logic [BUTTON_W-1:0] b, input logic pin);
      int gap;
      gap = send_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_button_id  <= b;
      req_pin_active <= pin;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      fresh_count = classify_sample(b, pin);
      for (int i = 0; i < fresh_count; i++) pending_events.push_back(fresh_events[i]);
      samples_sent++;
   endtask

   // Stops sending and waits until every predicted event has come out.
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all eight registers from next_regs, one item per register.
   task automatic load_config();
      csr_reg_type reg_id;
      for (int i = 0; i < NUM_REGS; i++) begin
         reg_id = csr_reg_type'(i);
         csr_valid <= 1'b1;
         csr_index <= reg_id;
         csr_data  <= next_regs[i];
         @(negedge clock);
         while (!csr_ready) @(negedge clock);
         @(posedge clock);
         apply_reg(reg_id, next_regs[i]);
      end
      csr_valid <= 1'b0;
      config_loads++;
   endtask

   // Result side: random stalls, then each event is checked against the oldest prediction.
   initial begin : result_check
      int          stall;
      evt_rec_type want;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
         while (!rsp_valid) @(negedge clock);
         results_seen++;
         if (pending_events.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOWN_MISMATCHES)
               $display("Unexpected event: button %0d kind %0d value %0d last %0b",
                        rsp_event_button, rsp_event_kind, rsp_event_value, rsp_last_event);
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_button !== want.button || rsp_event_kind !== want.kind ||
                rsp_event_value !== want.value || rsp_last_event !== want.last) begin
               fail_count++;
               if (fail_count <= SHOWN_MISMATCHES)
                  $display("Event %0d differs: expected button %0d kind %0d value %0d ",
                           results_seen, want.button, want.kind, want.value,
                           "last %0b, got button %0d kind %0d value %0d last %0b",
                           want.last, rsp_event_button, rsp_event_kind,
                           rsp_event_value, rsp_last_event);
            end
         end
         @(posedge clock);
      end
   end

   // Stimulus: directed table, then random gestures under four settings.
   initial begin : stimulus
      int                  phase;
      int                  k;
      int                  phase_start;
      int                  press_len;
      int                  rel_len;
      int                  hold_reach;
      int                  rel_reach;
      int                  deb;
      logic [BUTTON_W-1:0] focus;
      logic [BUTTON_W-1:0] b;

      clear_shadow();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows; typed rows also check the predicted count and first kind.
      foreach (directed_rows[i]) begin
         send_sample(directed_rows[i].button, directed_rows[i].pin);
         if (directed_rows[i].typed &&
             (fresh_count != directed_rows[i].typed_num ||
              (fresh_count > 0 && fresh_events[0].kind != directed_rows[i].typed_kind))) begin
            fail_count++;
            if (fail_count <= SHOWN_MISMATCHES)
               $display("Directed row %0d: expected %0d events, predicted %0d", i,
                        directed_rows[i].typed_num, fresh_count);
         end
      end
      wait_for_quiet();

      // Random press and release gestures on a favored button, with stray samples mixed in.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               next_regs[REG_MODE_BITS]        = CFG_W'($urandom);
               next_regs[REG_DEBOUNCE_COUNT]   = 16'd1;
               next_regs[REG_CLICK_GAP_TICKS]  = CFG_W'($urandom_range(2, 5));
               next_regs[REG_HOLD_START_TICKS] = CFG_W'($urandom_range(2, 5));
               next_regs[REG_HOLD_MARK_ONE]    = next_regs[REG_HOLD_START_TICKS] +
                                                 CFG_W'($urandom_range(1, 3));
               next_regs[REG_HOLD_MARK_THREE]  = next_regs[REG_HOLD_MARK_ONE] +
                                                 CFG_W'($urandom_range(1, 3));
               next_regs[REG_HOLD_MARK_FIVE]   = next_regs[REG_HOLD_MARK_THREE] +
                                                 CFG_W'($urandom_range(1, 3));
               next_regs[REG_HOLD_MARK_TEN]    = next_regs[REG_HOLD_MARK_FIVE] +
                                                 CFG_W'($urandom_range(1, 3));
               hold_reach = 20;
            end
            1: begin
               // Zero debounce: both sides are evaluated on every sample.
               next_regs[REG_MODE_BITS]        = 16'hFFFF;
               next_regs[REG_DEBOUNCE_COUNT]   = 16'd0;
               next_regs[REG_CLICK_GAP_TICKS]  = 16'd0;
               next_regs[REG_HOLD_START_TICKS] = 16'd0;
               next_regs[REG_HOLD_MARK_ONE]    = CFG_W'($urandom_range(0, 12));
               next_regs[REG_HOLD_MARK_THREE]  = CFG_W'($urandom_range(0, 12));
               next_regs[REG_HOLD_MARK_FIVE]   = CFG_W'($urandom_range(0, 12));
               next_regs[REG_HOLD_MARK_TEN]    = CFG_W'($urandom_range(0, 12));
               hold_reach = 14;
            end
            2: begin
               next_regs[REG_MODE_BITS]        = CFG_W'($urandom);
               next_regs[REG_DEBOUNCE_COUNT]   = CFG_W'($urandom_range(2, 3));
               next_regs[REG_CLICK_GAP_TICKS]  = CFG_W'($urandom_range(3, 6));
               next_regs[REG_HOLD_START_TICKS] = CFG_W'($urandom_range(3, 6));
               next_regs[REG_HOLD_MARK_ONE]    = CFG_W'($urandom_range(0, 16));
               next_regs[REG_HOLD_MARK_THREE]  = CFG_W'($urandom_range(0, 16));
               next_regs[REG_HOLD_MARK_FIVE]   = CFG_W'($urandom_range(0, 16));
               next_regs[REG_HOLD_MARK_TEN]    = CFG_W'($urandom_range(0, 16));
               hold_reach = 20;
            end
            default: begin
               // Every event disabled but indicate; the debounce write carries a high byte.
               next_regs[REG_MODE_BITS]        = 16'h0000;
               next_regs[REG_DEBOUNCE_COUNT]   = 16'hFF01;
               next_regs[REG_CLICK_GAP_TICKS]  = 16'd1;
               next_regs[REG_HOLD_START_TICKS] = 16'd1;
               next_regs[REG_HOLD_MARK_ONE]    = 16'd2;
               next_regs[REG_HOLD_MARK_THREE]  = 16'd3;
               next_regs[REG_HOLD_MARK_FIVE]   = 16'd4;
               next_regs[REG_HOLD_MARK_TEN]    = 16'd5;
               hold_reach = 8;
            end
         endcase
         load_config();
         deb         = int'(cfg_shadow.debounce_count);
         rel_reach   = int'(cfg_shadow.click_gap_ticks) + deb + 2;
         focus       = BUTTON_W'($urandom_range(0, NBTN - 1));
         phase_start = samples_sent;
         while (samples_sent - phase_start < PHASE_ITEMS) begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on  = ($urandom_range(0, 3) != 0);
            b = ($urandom_range(0, 9) < 7) ? focus : BUTTON_W'($urandom_range(0, NBTN - 1));
            press_len = $urandom_range(0, 1) ? $urandom_range(1, deb + 2)
                                             : $urandom_range(1, hold_reach + deb);
            rel_len   = $urandom_range(0, 1) ? $urandom_range(1, deb + 2)
                                             : $urandom_range(1, rel_reach);
            for (k = 0; k < press_len + rel_len &&
                        samples_sent - phase_start < PHASE_ITEMS; k++) begin
               if ($urandom_range(0, 7) == 0)
                  send_sample(BUTTON_W'($urandom_range(0, NBTN - 1)), 1'($urandom_range(0, 1)));
               send_sample(b, k < press_len);
            end
         end
         wait_for_quiet();
      end

      fail_count += pending_events.size();
      $display("Run covered %0d samples and %0d events under %0d register settings,",
               samples_sent, results_seen, config_loads + 1);
      $display("including zero debounce, a masked debounce write and all events but indicate off.");
      if (fail_count == 0) begin
         $display("button_press_hold_classifier: match");
      end else begin
         $display("button_press_hold_classifier: mismatch");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("button_press_hold_classifier: mismatch");
      $finish;
   end

endmodule
